[rtl/ncr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_pkg: shared types and constants for the character reference decoder
// Transaction payloads, the encoded-group record passed from the parser to
// the output serialiser, and the code point and UTF-8 constants.
// ----------------------------------------------------------------------------
package ncr_pkg;

    // Input transaction: one byte of reference text
    typedef struct packed {
        logic [7:0] ref_byte;
        logic       ref_last;
    } ncr_in_t;

    // Output transaction: one UTF-8 byte or a single error marker
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       out_last;
        logic       status;
    } ncr_out_t;

    // One decoded reference, ready to be serialised
    typedef struct packed {
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final byte
        logic            err;
    } ncr_group_t;

    // Parser to serialiser push
    typedef struct packed {
        logic       valid;
        ncr_group_t group;
    } ncr_push_t;

    // Enough groups for a four-byte character followed by lone terminators
    localparam int NCR_GROUP_DEPTH = 5;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_MAX_1BYTE = 21'h00007F;
    localparam logic [20:0] CP_MAX_2BYTE = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3BYTE = 21'h00FFFF;

    localparam logic [7:0] LEAD_2BYTE = 8'hC0;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_LX    = 8'h78;

endpackage

[rtl/ncr_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_parse: reference parser and UTF-8 encoder
// Tracks byte position, base, digits and the running code point per byte;
// on the terminator it encodes the held code point into a byte group.
// ----------------------------------------------------------------------------
module ncr_parse
    import ncr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  ncr_in_t   ref_data,
    output ncr_push_t push
);

    logic [1:0]  pos_reg,  pos_next;
    logic        hex_reg,  hex_next;
    logic        seen_reg, seen_next;
    logic [20:0] cp_reg,   cp_next;
    logic        bad_reg,  bad_next;

    logic [7:0]  b;
    logic        is_dec;
    logic        is_lhex;
    logic        is_uhex;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [24:0] cp_ext;
    logic [24:0] scaled;
    logic [24:0] acc;

    assign b = ref_data.ref_byte;

    // Digit decode in the current base
    always_comb
    begin
        is_dec  = (b >= CHAR_0)  && (b <= CHAR_9);
        is_lhex = hex_reg && (b >= CHAR_LA) && (b <= CHAR_LF);
        is_uhex = hex_reg && (b >= CHAR_UA) && (b <= CHAR_UF);
        digit_ok = is_dec || is_lhex || is_uhex;
        priority if (is_dec)
            digit = 4'(b - CHAR_0);
        else if (is_lhex)
            digit = 4'(b - CHAR_LA + 8'd10);
        else if (is_uhex)
            digit = 4'(b - CHAR_UA + 8'd10);
        else
            digit = 4'd0;
    end

    // Accumulate: times 16 or times 10, plus the digit
    always_comb
    begin
        cp_ext = 25'(cp_reg);
        if (hex_reg)
            scaled = cp_ext << 4;
        else
            scaled = (cp_ext << 3) + (cp_ext << 1);
        acc = scaled + 25'(digit);
    end

    // Parser state update
    always_comb
    begin
        pos_next  = pos_reg;
        hex_next  = hex_reg;
        seen_next = seen_reg;
        cp_next   = cp_reg;
        bad_next  = bad_reg;
        if (take)
        begin
            if (ref_data.ref_last)
            begin
                pos_next  = 2'd0;
                hex_next  = 1'b0;
                seen_next = 1'b0;
                cp_next   = 21'd0;
                bad_next  = 1'b0;
            end
            else
            begin
                if (pos_reg == 2'd1)
                begin
                    if (b != CHAR_HASH)
                        bad_next = 1'b1;
                end
                else if ((pos_reg == 2'd2) && ((b == CHAR_LX) || (b == CHAR_UX)))
                begin
                    hex_next = 1'b1;
                end
                else if ((pos_reg != 2'd0) && !bad_reg)
                begin
                    // digit byte
                    seen_next = 1'b1;
                    if (!digit_ok || (acc > 25'(CP_MAX)))
                        bad_next = 1'b1;
                    else
                        cp_next = acc[20:0];
                end
                if (pos_reg != 2'd3)
                    pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            hex_reg  <= 1'b0;
            seen_reg <= 1'b0;
            cp_reg   <= 21'd0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            hex_reg  <= hex_next;
            seen_reg <= seen_next;
            cp_reg   <= cp_next;
            bad_reg  <= bad_next;
        end
    end

    // Encode the held code point on the terminator
    always_comb
    begin
        push.valid       = take && ref_data.ref_last;
        push.group.bytes = '0;
        push.group.err   = STATUS_OK;
        if ((pos_reg != 2'd3) || bad_reg || !seen_reg)
        begin
            push.group.last_idx = 2'd0;
            push.group.err      = STATUS_BAD;
        end
        else if (cp_reg <= CP_MAX_1BYTE)
        begin
            push.group.bytes[0] = cp_reg[7:0];
            push.group.last_idx = 2'd0;
        end
        else if (cp_reg <= CP_MAX_2BYTE)
        begin
            push.group.bytes[0] = LEAD_2BYTE | {3'b000, cp_reg[10:6]};
            push.group.bytes[1] = CONT_BYTE  | {2'b00, cp_reg[5:0]};
            push.group.last_idx = 2'd1;
        end
        else if (cp_reg <= CP_MAX_3BYTE)
        begin
            push.group.bytes[0] = LEAD_3BYTE | {4'b0000, cp_reg[15:12]};
            push.group.bytes[1] = CONT_BYTE  | {2'b00, cp_reg[11:6]};
            push.group.bytes[2] = CONT_BYTE  | {2'b00, cp_reg[5:0]};
            push.group.last_idx = 2'd2;
        end
        else
        begin
            push.group.bytes[0] = LEAD_4BYTE | {5'b00000, cp_reg[20:18]};
            push.group.bytes[1] = CONT_BYTE  | {2'b00, cp_reg[17:12]};
            push.group.bytes[2] = CONT_BYTE  | {2'b00, cp_reg[11:6]};
            push.group.bytes[3] = CONT_BYTE  | {2'b00, cp_reg[5:0]};
            push.group.last_idx = 2'd3;
        end
    end

endmodule

[rtl/ncr_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncr_serial: group queue and byte serialiser
// Holds decoded references in a small register queue and sends the head
// group out one byte per output transaction.
// ----------------------------------------------------------------------------
module ncr_serial
    import ncr_pkg::*;
#(
    parameter int GROUP_DEPTH = NCR_GROUP_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ncr_push_t push,
    output logic      full,
    output logic      utf8_valid,
    input  logic      utf8_ready,
    output ncr_out_t  utf8_data
);

    localparam int PW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CW = $clog2(GROUP_DEPTH + 1);

    ncr_group_t      mem [GROUP_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [1:0]      idx_reg,    idx_next;
    ncr_group_t      head;
    logic            pop;

    assign head       = mem[rd_ptr_reg];
    assign full       = (count_reg == CW'(GROUP_DEPTH));
    assign utf8_valid = (count_reg != '0);

    // Output byte comes straight from the registered head group
    always_comb
    begin
        utf8_data.utf8_byte = head.bytes[idx_reg];
        utf8_data.out_last  = (idx_reg == head.last_idx);
        utf8_data.status    = head.err;
    end

    assign pop = utf8_valid && utf8_ready && utf8_data.out_last;

    // Pointer, count and byte index update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        if (push.valid)
        begin
            if (wr_ptr_reg == PW'(GROUP_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (utf8_valid && utf8_ready)
        begin
            if (pop)
            begin
                idx_next = 2'd0;
                if (rd_ptr_reg == PW'(GROUP_DEPTH - 1))
                    rd_ptr_next = '0;
                else
                    rd_ptr_next = rd_ptr_reg + PW'(1);
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (push.valid && !pop)
            count_next = count_reg + CW'(1);
        else if (!push.valid && pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.group;
    end

    // Checks
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (!full || pop))
        else $error("group pushed into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(GROUP_DEPTH))
        else $error("queue count beyond depth");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (utf8_valid && utf8_data.status) |->
            (utf8_data.out_last && (utf8_data.utf8_byte == 8'd0)))
        else $error("error result is not a single zero byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_valid |-> (idx_reg <= head.last_idx))
        else $error("byte index ran past the end of the group");

    a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 2'd0))
        else $error("byte index not cleared after group sent");

endmodule

[rtl/numeric_char_ref_to_utf8_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_char_ref_to_utf8_core: numeric character reference to UTF-8
// Top level: byte parser and encoder feeding a queued output serialiser.
// ----------------------------------------------------------------------------
// The block takes one reference byte per clock and never stalls on ordinary
// bytes: parsing and the times-ten or times-sixteen accumulation are done in
// the cycle the byte is accepted. When the terminating byte is accepted the
// held code point is encoded into a group of one to four UTF-8 bytes (or one
// error result) and placed in a register queue of GROUP_DEPTH references;
// the group is offered once it reaches the head of the queue and goes out one
// byte per output transaction. The terminator is only held back when that
// queue is full. A reference never yields more output bytes than it has input
// bytes, and the default depth of five references covers the worst burst, a
// four-byte character followed by back-to-back lone terminators that each
// give an error result, so with a consumer taking one byte per cycle the
// input runs at one byte per cycle.
module numeric_char_ref_to_utf8_core
    import ncr_pkg::*;
#(
    parameter int GROUP_DEPTH = NCR_GROUP_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     ref_valid,
    output logic     ref_ready,
    input  ncr_in_t  ref_data,
    output logic     utf8_valid,
    input  logic     utf8_ready,
    output ncr_out_t utf8_data
);

    ncr_push_t push;
    logic      full;
    logic      take;

    // Only a terminator needs queue space
    assign ref_ready = !full || !ref_data.ref_last;
    assign take      = ref_valid && ref_ready;

    ncr_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ref_data (ref_data),
        .push     (push)
    );

    ncr_serial #(
        .GROUP_DEPTH (GROUP_DEPTH)
    ) u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .utf8_valid (utf8_valid),
        .utf8_ready (utf8_ready),
        .utf8_data  (utf8_data)
    );

endmodule

[test/numeric_char_ref_to_utf8_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_char_ref_to_utf8_core_tb: self-checking bench for the reference decoder
// Streams numeric character references byte by byte into the core, predicts
// the UTF-8 bytes or error marker each terminator should produce, and checks
// every output transaction in order. Runs a directed set of malformed and
// boundary references, then random ones, under changing back-pressure.
// ----------------------------------------------------------------------------

import ncr_pkg::*;

// Tracks parser state for the stream of reference bytes and holds the
// UTF-8 bytes still owed by the core
class utf8_result_board;

    logic [1:0]  pos;
    logic        hex;
    logic        seen;
    logic [20:0] cp;
    logic        bad;
    ncr_out_t    expected_utf8[$];
    int          failures;

    function new();
        clear_ref();
        failures = 0;
    endfunction

    function void clear_ref();
        pos  = 2'd0;
        hex  = 1'b0;
        seen = 1'b0;
        cp   = '0;
        bad  = 1'b0;
    endfunction

    function int pending();
        return expected_utf8.size();
    endfunction

    function void push_result(logic [7:0] b, logic last, logic status);
        ncr_out_t r;
        r.utf8_byte = b;
        r.out_last  = last;
        r.status    = status;
        expected_utf8.insert(expected_utf8.size(), r);
    endfunction

    // Accumulate one digit in the current base; an invalid digit or a value
    // past the top code point poisons the reference, keeping the old value
    function void absorb_digit(logic [7:0] b);
        int unsigned d;
        int unsigned next;
        if (bad)
            return;
        seen = 1'b1;
        if (b >= CHAR_0 && b <= CHAR_9)
            d = b - CHAR_0;
        else if (hex && b >= CHAR_LA && b <= CHAR_LF)
            d = b - CHAR_LA + 10;
        else if (hex && b >= CHAR_UA && b <= CHAR_UF)
            d = b - CHAR_UA + 10;
        else
        begin
            bad = 1'b1;
            return;
        end
        next = cp * (hex ? 16 : 10) + d;
        if (next > CP_MAX)
            bad = 1'b1;
        else
            cp = next[20:0];
    endfunction

    function void encode_code_point();
        if (cp <= CP_MAX_1BYTE)
            push_result(cp[7:0], 1'b1, STATUS_OK);
        else if (cp <= CP_MAX_2BYTE)
        begin
            push_result(LEAD_2BYTE | {3'b0, cp[10:6]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[5:0]}, 1'b1, STATUS_OK);
        end
        else if (cp <= CP_MAX_3BYTE)
        begin
            push_result(LEAD_3BYTE | {4'b0, cp[15:12]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[11:6]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[5:0]}, 1'b1, STATUS_OK);
        end
        else
        begin
            push_result(LEAD_4BYTE | {5'b0, cp[20:18]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[17:12]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[11:6]}, 1'b0, STATUS_OK);
            push_result(CONT_BYTE | {2'b0, cp[5:0]}, 1'b1, STATUS_OK);
        end
    endfunction

    // Called for every accepted input transaction
    function void note_ref_byte(ncr_in_t t);
        if (t.ref_last)
        begin
            if (pos != 2'd3 || bad || !seen)
                push_result(8'h00, 1'b1, STATUS_BAD);
            else
                encode_code_point();
            clear_ref();
        end
        else
        begin
            case (pos)
                2'd1:
                    if (t.ref_byte != CHAR_HASH)
                        bad = 1'b1;
                2'd2:
                    if (t.ref_byte == CHAR_LX || t.ref_byte == CHAR_UX)
                        hex = 1'b1;
                    else
                        absorb_digit(t.ref_byte);
                2'd3:
                    absorb_digit(t.ref_byte);
                default:
                    ;
            endcase
            if (pos != 2'd3)
                pos = pos + 2'd1;
        end
    endfunction

    // Called for every accepted output transaction
    function void check_utf8_byte(ncr_out_t got);
        ncr_out_t want;
        if (expected_utf8.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected output byte=%h last=%b status=%b",
                         $realtime, got.utf8_byte, got.out_last, got.status);
            return;
        end
        want = expected_utf8.pop_front();
        if (got.utf8_byte !== want.utf8_byte || got.out_last !== want.out_last ||
            got.status !== want.status)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch byte=%h/%h last=%b/%b status=%b/%b (exp/act)",
                         $realtime, want.utf8_byte, got.utf8_byte, want.out_last,
                         got.out_last, want.status, got.status);
        end
    endfunction

endclass

module numeric_char_ref_to_utf8_core_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BYTES    = 83;
    localparam int DRAIN_CYCLES   = 20;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     ref_valid  = 1'b0;
    logic     ref_ready;
    ncr_in_t  ref_data   = '0;
    logic     utf8_valid;
    logic     utf8_ready = 1'b0;
    ncr_out_t utf8_data;

    utf8_result_board tracker;
    logic [7:0]       ref_text[$];
    int               bytes_sent     = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               idle_cycles    = 0;

    numeric_char_ref_to_utf8_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .ref_valid  (ref_valid),
        .ref_ready  (ref_ready),
        .ref_data   (ref_data),
        .utf8_valid (utf8_valid),
        .utf8_ready (utf8_ready),
        .utf8_data  (utf8_data)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        utf8_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Transaction monitor: inputs feed the predictor, outputs are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ref_valid && ref_ready)
                tracker.note_ref_byte(ref_data);
            if (utf8_valid && utf8_ready)
                tracker.check_utf8_byte(utf8_data);
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((ref_valid && ref_ready) || (utf8_valid && utf8_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Append one byte to the reference text being built
    function automatic void add_text_byte(input logic [7:0] b);
        ref_text.insert(ref_text.size(), b);
    endfunction

    // One byte, held until accepted; random idle cycles in front of it
    task automatic send_ref_byte(input logic [7:0] b, input logic last);
        ncr_in_t item;
        item.ref_byte = b;
        item.ref_last = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            ref_valid <= 1'b0;
            @(posedge clk);
        end
        ref_valid <= 1'b1;
        ref_data  <= item;
        do
            @(posedge clk);
        while (!ref_ready);
        bytes_sent++;
    endtask

    // The final byte of ref_text is the terminator
    task automatic send_ref_text();
        for (int i = 0; i < ref_text.size(); i++)
            send_ref_byte(ref_text[i], i == ref_text.size() - 1);
    endtask

    task automatic send_text(input logic [7:0] lead, input string body,
                             input logic [7:0] term);
        ref_text.delete();
        add_text_byte(lead);
        for (int i = 0; i < body.len(); i++)
            add_text_byte(body[i]);
        add_text_byte(term);
        send_ref_text();
    endtask

    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return CHAR_0 + 8'($urandom_range(9));
            2:       return ($urandom_range(1) ? CHAR_LA : CHAR_UA) + 8'($urandom_range(6));
            default: return $urandom_range(1) ? CHAR_LX : CHAR_UX;
        endcase
    endfunction

    // Code points by UTF-8 length, encoding boundaries, surrogates, overflow
    function automatic int unsigned pick_code_point();
        int unsigned edges[11] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                                   32'h10000, 32'h10FFFF, 32'h110000, 32'hD800,
                                   32'hDFFF};
        case ($urandom_range(5))
            0:       return $urandom_range(32'h7F);
            1:       return $urandom_range(32'h7FF, 32'h80);
            2:       return $urandom_range(32'hFFFF, 32'h800);
            3:       return $urandom_range(32'h10FFFF, 32'h10000);
            4:       return edges[$urandom_range(10)];
            default: return $urandom_range(32'hFFFFFFF, 32'h110000);
        endcase
    endfunction

    // Digits most significant first, hex letters in random case
    function automatic void append_number(int unsigned value, bit use_hex);
        logic [7:0]  digits[$];
        int unsigned d;
        int unsigned base;
        base = use_hex ? 16 : 10;
        do
        begin
            d = value % base;
            value = value / base;
            if (d < 10)
                digits.push_front(CHAR_0 + 8'(d));
            else
                digits.push_front(($urandom_range(1) ? CHAR_LA : CHAR_UA) + 8'(d - 10));
        end
        while (value != 0);
        foreach (digits[i])
            add_text_byte(digits[i]);
    endfunction

    // Mostly well-formed references, some corrupted, the rest noise
    task automatic send_random_ref();
        int kind;
        int n;
        bit use_hex;
        ref_text.delete();
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            add_text_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h26);
            add_text_byte(CHAR_HASH);
            use_hex = $urandom_range(1);
            if (use_hex)
                add_text_byte($urandom_range(1) ? CHAR_LX : CHAR_UX);
            repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0)
                add_text_byte(CHAR_0);
            append_number(pick_code_point(), use_hex);
            if (kind < 10)
                ref_text[$urandom_range(ref_text.size() - 1, 1)] = pick_noise_byte();
        end
        else
        begin
            n = $urandom_range(8);
            for (int i = 0; i < n; i++)
                add_text_byte((i == 1 && $urandom_range(1)) ? CHAR_HASH : pick_noise_byte());
        end
        add_text_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h3B);
        send_ref_text();
    endtask

    initial
    begin
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase

            if (ph == 0)
            begin
                // short, missing hash, no digits, late hex marker, zero, overflow
                send_text(8'h00, "#",       8'h3B);
                send_text(8'h26, "%5",      8'hFF);
                send_text(8'hFF, "#x",      8'h3B);
                send_text(8'h26, "#9x",     8'h3B);
                send_text(8'h26, "#0",      8'h3B);
                send_text(8'h26, "#x110000", 8'h3B);
            end

            while (bytes_sent < 30 + PHASE_BYTES * (ph + 1))
                send_random_ref();

            // let the core drain completely before the next phase
            ref_valid <= 1'b0;
            do
                @(posedge clk);
            while (tracker.pending() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
